@@ sv/rtml_pkg.sv @@
// Shared types and constants of the rich text markup lexer.
// No dependencies; the lexer RTL and the testbench import this package.
`timescale 1ns / 1ps

package rtml_pkg;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_SLASH   = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_TAGS    = 3'd4,
    MODE_NAME    = 3'd5,
    MODE_TITLE   = 3'd6
  } rtml_mode_e;

  // Result kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_SEP   = 2'd1;
  localparam logic [1:0] KIND_NAME  = 2'd2;
  localparam logic [1:0] KIND_TITLE = 2'd3;

  // Style bit positions
  localparam int unsigned ST_BOLD   = 0;
  localparam int unsigned ST_ITALIC = 1;
  localparam int unsigned ST_UNDER  = 2;
  localparam int unsigned ST_STRIKE = 3;
  localparam int unsigned ST_SUB    = 4;
  localparam int unsigned ST_SUPER  = 5;

  // Characters with a markup meaning
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Default depth of the result queue
  localparam int unsigned RQ_DEPTH = 4;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] kind;
    logic       new_block;
    logic [5:0] style;
    logic [1:0] separator_level;
    logic       last;
  } rtml_res_t;

endpackage

@@ sv/rtml_in_if.sv @@
// Input channel of the markup lexer: one text byte per beat.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface rtml_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

@@ sv/rtml_out_if.sv @@
// Output channel of the markup lexer: one styled result per beat.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface rtml_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] kind;
  logic       new_block;
  logic [5:0] style;
  logic [1:0] separator_level;
  logic       last;

  modport source (output valid, output out_char, output kind, output new_block,
                  output style, output separator_level, output last, input ready);
  modport sink   (input valid, input out_char, input kind, input new_block,
                  input style, input separator_level, input last, output ready);
endinterface

@@ sv/rich_text_markup_lexer.sv @@
// Top level of the rich text markup lexer: input stage, decode core, result queue.
// Depends on rtml_pkg, rtml_in_if, rtml_out_if, rtml_core and rtml_rq.
//
//  port    dir   beat payload
//  in_i    sink  in_char, one document byte
//  out_o   src   out_char, kind, new_block, style, separator_level, last
//
// A byte is registered on accept and decoded, once the queue has room, into zero, one or
// two results that enter a small result queue; one byte per cycle is taken while
// the queue has room. A byte that yields two results (separator or space plus char)
// puts the output side behind the input, absorbed by the queue until it nears full.
// Reset: normal mode, all runs and style zero, a new block pending.
// Output stalls hold the queue head; the input stalls only when the queue
// cannot take two more results.
`timescale 1ns / 1ps

module rich_text_markup_lexer #(
  parameter int unsigned Depth = rtml_pkg::RQ_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rtml_in_if.sink           in_i,
  rtml_out_if.source        out_o
);
  import rtml_pkg::*;

  logic       stg_vld_q, stg_vld_d;
  logic [7:0] stg_char_q;
  logic       fire, room;
  logic [1:0] push_n;
  rtml_res_t  res0, res1, head;

  assign fire       = stg_vld_q && room;
  assign in_i.ready = !stg_vld_q || fire;

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (in_i.valid && in_i.ready) stg_vld_d = 1'b1;
    else if (fire) stg_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stg_vld_q <= 1'b0;
    else stg_vld_q <= stg_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) stg_char_q <= in_i.in_char;
  end

  rtml_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .char_i   (stg_char_q),
    .push_n_o (push_n),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  rtml_rq #(.Depth(Depth)) u_rq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (fire ? push_n : 2'd0),
    .res0_i   (res0),
    .res1_i   (res1),
    .pop_i    (out_o.valid && out_o.ready),
    .room_o   (room),
    .valid_o  (out_o.valid),
    .head_o   (head)
  );

  assign out_o.out_char        = head.out_char;
  assign out_o.kind            = head.kind;
  assign out_o.new_block       = head.new_block;
  assign out_o.style           = head.style;
  assign out_o.separator_level = head.separator_level;
  assign out_o.last            = head.last;

endmodule

@@ sv/rtml_core.sv @@
// Lexer state and per-byte decode: up to two results per byte.
// Depends on rtml_pkg.
`timescale 1ns / 1ps

module rtml_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         char_i,
  output logic [1:0]         push_n_o,
  output rtml_pkg::rtml_res_t res0_o,
  output rtml_pkg::rtml_res_t res1_o
);
  import rtml_pkg::*;

  rtml_mode_e mode_q, mode_d;
  logic [3:0] nl_q, nl_d;
  logic [1:0] star_q, star_d, us_q, us_d, tilde_q, tilde_d;
  logic       caret_q, caret_d;
  logic [5:0] style_q, style_d;
  logic       bp_q, bp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      nl_q    <= 4'd0;
      star_q  <= 2'd0;
      us_q    <= 2'd0;
      tilde_q <= 2'd0;
      caret_q <= 1'b0;
      style_q <= 6'd0;
      bp_q    <= 1'b1;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      nl_q    <= nl_d;
      star_q  <= star_d;
      us_q    <= us_d;
      tilde_q <= tilde_d;
      caret_q <= caret_d;
      style_q <= style_d;
      bp_q    <= bp_d;
    end
  end

  always_comb begin
    logic       do_normal;
    logic       nb;
    logic       pre_vld;
    rtml_res_t  pre;
    mode_d    = mode_q;
    nl_d      = nl_q;
    star_d    = star_q;
    us_d      = us_q;
    tilde_d   = tilde_q;
    caret_d   = caret_q;
    style_d   = style_q;
    bp_d      = bp_q;
    push_n_o  = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    do_normal = 1'b0;
    nb        = 1'b0;
    pre_vld   = 1'b0;
    pre       = '0;

    unique case (mode_q)
      MODE_ESCAPE: begin
        mode_d   = MODE_NORMAL;
        res0_o   = '{out_char: char_i, kind: KIND_TEXT, new_block: 1'b0,
                     style: style_q, separator_level: 2'd0, last: 1'b1};
        push_n_o = 2'd1;
      end
      MODE_SLASH: begin
        mode_d = MODE_NORMAL;
        if (char_i == CH_SLASH) begin
          if (nl_q != 4'd0) nl_d = nl_q - 4'd1;
          mode_d = MODE_COMMENT;
        end else begin
          do_normal = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (char_i == CH_NL) mode_d = MODE_NORMAL;
      end
      MODE_TAGS: begin
        if (char_i == CH_LBRACE) mode_d = MODE_NAME;
      end
      MODE_NAME, MODE_TITLE: begin
        if (char_i == CH_RBRACE) begin
          if (mode_q == MODE_NAME) begin
            mode_d = MODE_TITLE;
          end else begin
            mode_d = MODE_NORMAL;
            bp_d   = 1'b1;
          end
        end else begin
          res0_o   = '{out_char: char_i,
                       kind: (mode_q == MODE_NAME) ? KIND_NAME : KIND_TITLE,
                       new_block: bp_q, style: style_q, separator_level: 2'd0,
                       last: 1'b1};
          bp_d     = 1'b0;
          push_n_o = 2'd1;
        end
      end
      default: begin
        mode_d    = MODE_NORMAL;
        do_normal = 1'b1;
      end
    endcase

    if (do_normal) begin
      unique case (char_i)
        CH_NL: begin
          if (nl_q != 4'd15) nl_d = nl_q + 4'd1;
          if (nl_d > 4'd1) bp_d = 1'b1;
        end
        CH_STAR: begin
          star_d = (star_q == 2'd3) ? 2'd3 : star_q + 2'd1;
          bp_d   = 1'b1;
        end
        CH_US: begin
          us_d = (us_q == 2'd3) ? 2'd3 : us_q + 2'd1;
          bp_d = 1'b1;
        end
        CH_TILDE: begin
          tilde_d = (tilde_q == 2'd3) ? 2'd3 : tilde_q + 2'd1;
          bp_d    = 1'b1;
        end
        CH_CARET: begin
          caret_d = 1'b1;
          bp_d    = 1'b1;
        end
        CH_LBRACE: begin
          mode_d = MODE_TAGS;
          bp_d   = 1'b1;
        end
        CH_BSLASH: mode_d = MODE_ESCAPE;
        CH_SLASH: begin
          if (nl_q != 4'd0) mode_d = MODE_SLASH;
        end
        CH_HASH: begin
          if (nl_q != 4'd0) begin
            nl_d   = nl_q - 4'd1;
            mode_d = MODE_COMMENT;
          end
        end
        default: begin
          if (bp_q) begin
            // separator ahead of the block when two or more newlines ran
            if (nl_q > 4'd1) begin
              pre_vld = 1'b1;
              pre     = '{out_char: 8'd0, kind: KIND_SEP, new_block: 1'b1,
                          style: 6'd0,
                          separator_level: (nl_q >= 4'd4) ? 2'd3 : nl_q[1:0] - 2'd1,
                          last: 1'b0};
              nl_d    = 4'd0;
            end
            if (star_q == 2'd1) begin
              style_d[ST_BOLD] = ~style_d[ST_BOLD];
            end else if (star_q >= 2'd2) begin
              if (style_d[ST_BOLD] && style_d[ST_ITALIC]) begin
                style_d[ST_BOLD]   = 1'b0;
                style_d[ST_ITALIC] = 1'b0;
              end else begin
                style_d[ST_BOLD]   = 1'b1;
                style_d[ST_ITALIC] = 1'b1;
              end
            end
            if (us_q == 2'd1) style_d[ST_ITALIC] = ~style_d[ST_ITALIC];
            else if (us_q >= 2'd2) style_d[ST_UNDER] = ~style_d[ST_UNDER];
            if (tilde_q == 2'd1) style_d[ST_SUB] = ~style_d[ST_SUB];
            else if (tilde_q >= 2'd2) style_d[ST_STRIKE] = ~style_d[ST_STRIKE];
            if (caret_q) style_d[ST_SUPER] = ~style_d[ST_SUPER];
            star_d  = 2'd0;
            us_d    = 2'd0;
            tilde_d = 2'd0;
            caret_d = 1'b0;
            bp_d    = 1'b0;
            nb      = 1'b1;
          end
          // single newline turns into a space ahead of the character
          if (nl_d == 4'd1) begin
            nl_d    = 4'd0;
            pre_vld = 1'b1;
            pre     = '{out_char: CH_SPACE, kind: KIND_TEXT, new_block: nb,
                        style: style_d, separator_level: 2'd0, last: 1'b0};
            nb      = 1'b0;
          end
          if (pre_vld) begin
            res0_o   = pre;
            res1_o   = '{out_char: char_i, kind: KIND_TEXT, new_block: nb,
                         style: style_d, separator_level: 2'd0, last: 1'b1};
            push_n_o = 2'd2;
          end else begin
            res0_o   = '{out_char: char_i, kind: KIND_TEXT, new_block: nb,
                         style: style_d, separator_level: 2'd0, last: 1'b1};
            push_n_o = 2'd1;
          end
        end
      endcase
    end
  end

endmodule

@@ sv/rtml_rq.sv @@
// Result queue: takes zero, one or two results a cycle, hands out one when popped.
// Depends on rtml_pkg for the result type.
`timescale 1ns / 1ps

module rtml_rq #(
  parameter int unsigned Depth = rtml_pkg::RQ_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  rtml_pkg::rtml_res_t res0_i,
  input  rtml_pkg::rtml_res_t res1_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                valid_o,
  output rtml_pkg::rtml_res_t head_o
);
  import rtml_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  rtml_res_t       mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp1;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign wp1     = (wp_q == LastIdx) ? '0 : wp_q + PtrW'(1);
  assign room_o  = (cnt_q <= RoomMax);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q + CntW'(push_n_i) - CntW'(pop_i);
    if (push_n_i == 2'd1) wp_d = wp1;
    else if (push_n_i == 2'd2) wp_d = (wp1 == LastIdx) ? '0 : wp1 + PtrW'(1);
    if (pop_i) rp_d = (rp_q == LastIdx) ? '0 : rp_q + PtrW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < Depth; i++) begin
      if (push_n_i != 2'd0 && wp_q == PtrW'(i)) mem_q[i] <= res0_i;
      if (push_n_i == 2'd2 && wp1 == PtrW'(i)) mem_q[i] <= res1_i;
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i != 2'd0 |-> room_o)
    else $error("result push without room");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd0 && pop_i) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("result queue count lost a pop");

endmodule

@@ tb/rich_text_markup_lexer_tb.sv @@
// Self-checking testbench of rich_text_markup_lexer: directed byte table, then random markup.
// Depends on rtml_pkg, rtml_in_if, rtml_out_if and the lexer RTL.
`timescale 1ns / 1ps

module rich_text_markup_lexer_tb;
  import rtml_pkg::*;

  localparam int unsigned RandBytes   = 1270;
  localparam int unsigned MaxCycles   = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned GapPct      = 27;
  localparam int unsigned DirRows     = 30;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;  // expectation written out in the row
    logic       none;   // typed row that yields no result
    rtml_res_t  res;
  } lex_row_t;

  // Rows with an expectation typed in; the rest go through the lexer predictor.
  localparam lex_row_t DirTab [DirRows] = '{
    '{8'h41,     1'b1, 1'b0, '{8'h41, KIND_TEXT, 1'b1, 6'd0, 2'd0, 1'b1}},
    '{8'hFF,     1'b1, 1'b0, '{8'hFF, KIND_TEXT, 1'b0, 6'd0, 2'd0, 1'b1}},
    '{8'h00,     1'b1, 1'b0, '{8'h00, KIND_TEXT, 1'b0, 6'd0, 2'd0, 1'b1}},
    '{CH_STAR,   1'b1, 1'b1, '0},
    '{CH_STAR,   1'b1, 1'b1, '0},
    '{CH_US,     1'b1, 1'b1, '0},
    '{CH_TILDE,  1'b1, 1'b1, '0},
    '{CH_CARET,  1'b1, 1'b1, '0},
    '{8'h62,     1'b0, 1'b0, '0},
    '{CH_NL,     1'b1, 1'b1, '0},
    '{CH_NL,     1'b1, 1'b1, '0},
    '{8'h63,     1'b0, 1'b0, '0},
    '{CH_NL,     1'b1, 1'b1, '0},
    '{CH_SLASH,  1'b1, 1'b1, '0},
    '{8'h64,     1'b0, 1'b0, '0},
    '{CH_HASH,   1'b1, 1'b1, '0},
    '{CH_BSLASH, 1'b1, 1'b1, '0},
    '{CH_STAR,   1'b0, 1'b0, '0},
    '{CH_NL,     1'b1, 1'b1, '0},
    '{CH_HASH,   1'b1, 1'b1, '0},
    '{8'h7A,     1'b1, 1'b1, '0},
    '{CH_NL,     1'b1, 1'b1, '0},
    '{CH_LBRACE, 1'b1, 1'b1, '0},
    '{8'h6B,     1'b1, 1'b1, '0},
    '{CH_LBRACE, 1'b1, 1'b1, '0},
    '{8'h6E,     1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b1, 1'b1, '0},
    '{8'h74,     1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b1, 1'b1, '0},
    '{8'h65,     1'b0, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  rtml_in_if  in_if ();
  rtml_out_if out_if ();

  rich_text_markup_lexer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lex_row_t  feed_q[$];
  rtml_res_t styled_q[$];
  rtml_res_t lexed[$];
  int        fails    = 0;
  int        bytes_in = 0;

  // Predictor state
  rtml_mode_e lx_mode   = MODE_NORMAL;
  logic [3:0] nl_cnt    = 4'd0;
  logic [1:0] star_cnt  = 2'd0;
  logic [1:0] us_cnt    = 2'd0;
  logic [1:0] tilde_cnt = 2'd0;
  logic       caret_hit = 1'b0;
  logic [5:0] style_q   = 6'd0;
  logic       blk_pend  = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [1:0] sat3(logic [1:0] v);
    return (v == 2'd3) ? 2'd3 : v + 2'd1;
  endfunction

  function automatic void emit(logic [7:0] ch, logic [1:0] kd, logic nb, logic [5:0] st,
                               logic [1:0] lvl);
    rtml_res_t r;
    r.out_char        = ch;
    r.kind            = kd;
    r.new_block       = nb;
    r.style           = st;
    r.separator_level = lvl;
    r.last            = 1'b0;
    lexed = {lexed, r};
  endfunction

  function automatic void lex_text(logic [7:0] c);
    logic nb;
    nb = 1'b0;
    case (c)
      CH_NL: begin
        if (nl_cnt != 4'd15) nl_cnt = nl_cnt + 4'd1;
        if (nl_cnt > 4'd1) blk_pend = 1'b1;
        return;
      end
      CH_STAR: begin
        star_cnt = sat3(star_cnt);
        blk_pend = 1'b1;
        return;
      end
      CH_US: begin
        us_cnt   = sat3(us_cnt);
        blk_pend = 1'b1;
        return;
      end
      CH_TILDE: begin
        tilde_cnt = sat3(tilde_cnt);
        blk_pend  = 1'b1;
        return;
      end
      CH_CARET: begin
        caret_hit = 1'b1;
        blk_pend  = 1'b1;
        return;
      end
      CH_LBRACE: begin
        lx_mode  = MODE_TAGS;
        blk_pend = 1'b1;
        return;
      end
      CH_BSLASH: begin
        lx_mode = MODE_ESCAPE;
        return;
      end
      CH_SLASH: begin
        if (nl_cnt != 4'd0) lx_mode = MODE_SLASH;
        return;
      end
      CH_HASH: begin
        if (nl_cnt != 4'd0) begin
          nl_cnt  = nl_cnt - 4'd1;
          lx_mode = MODE_COMMENT;
        end
        return;
      end
      default: ;
    endcase
    if (blk_pend) begin
      if (nl_cnt > 4'd1) begin
        emit(8'h00, KIND_SEP, 1'b1, 6'd0, (nl_cnt >= 4'd4) ? 2'd3 : nl_cnt[1:0] - 2'd1);
        nl_cnt = 4'd0;
      end
      if (star_cnt == 2'd1) begin
        style_q[ST_BOLD] = ~style_q[ST_BOLD];
      end else if (star_cnt >= 2'd2) begin
        // emphatic: clear both only when both are on
        if (style_q[ST_BOLD] && style_q[ST_ITALIC]) begin
          style_q[ST_BOLD]   = 1'b0;
          style_q[ST_ITALIC] = 1'b0;
        end else begin
          style_q[ST_BOLD]   = 1'b1;
          style_q[ST_ITALIC] = 1'b1;
        end
      end
      if (us_cnt == 2'd1) style_q[ST_ITALIC] = ~style_q[ST_ITALIC];
      else if (us_cnt >= 2'd2) style_q[ST_UNDER] = ~style_q[ST_UNDER];
      if (tilde_cnt == 2'd1) style_q[ST_SUB] = ~style_q[ST_SUB];
      else if (tilde_cnt >= 2'd2) style_q[ST_STRIKE] = ~style_q[ST_STRIKE];
      if (caret_hit) style_q[ST_SUPER] = ~style_q[ST_SUPER];
      star_cnt  = 2'd0;
      us_cnt    = 2'd0;
      tilde_cnt = 2'd0;
      caret_hit = 1'b0;
      blk_pend  = 1'b0;
      nb        = 1'b1;
    end
    if (nl_cnt == 4'd1) begin
      nl_cnt = 4'd0;
      emit(CH_SPACE, KIND_TEXT, nb, style_q, 2'd0);
      nb = 1'b0;
    end
    emit(c, KIND_TEXT, nb, style_q, 2'd0);
  endfunction

  function automatic void mention_byte(logic [7:0] c, logic [1:0] kd);
    emit(c, kd, blk_pend, style_q, 2'd0);
    blk_pend = 1'b0;
  endfunction

  // Advance the lexer by one byte; results land in lexed.
  function automatic void lex_byte(logic [7:0] c);
    lexed.delete();
    case (lx_mode)
      MODE_ESCAPE: begin
        lx_mode = MODE_NORMAL;
        emit(c, KIND_TEXT, 1'b0, style_q, 2'd0);
      end
      MODE_SLASH: begin
        lx_mode = MODE_NORMAL;
        if (c == CH_SLASH) begin
          if (nl_cnt != 4'd0) nl_cnt = nl_cnt - 4'd1;
          lx_mode = MODE_COMMENT;
        end else begin
          lex_text(c);
        end
      end
      MODE_COMMENT: if (c == CH_NL) lx_mode = MODE_NORMAL;
      MODE_TAGS:    if (c == CH_LBRACE) lx_mode = MODE_NAME;
      MODE_NAME: begin
        if (c == CH_RBRACE) lx_mode = MODE_TITLE;
        else mention_byte(c, KIND_NAME);
      end
      MODE_TITLE: begin
        if (c == CH_RBRACE) begin
          lx_mode  = MODE_NORMAL;
          blk_pend = 1'b1;
        end else begin
          mention_byte(c, KIND_TITLE);
        end
      end
      default: begin
        lx_mode = MODE_NORMAL;
        lex_text(c);
      end
    endcase
    if (lexed.size() != 0) lexed[$].last = 1'b1;
  endfunction

  function automatic bit is_markup(logic [7:0] c);
    return c inside {CH_NL, CH_STAR, CH_US, CH_TILDE, CH_CARET, CH_LBRACE, CH_BSLASH,
                     CH_SLASH, CH_HASH};
  endfunction

  function automatic logic [7:0] rnd_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_markup(c));
    return c;
  endfunction

  function automatic logic [7:0] rnd_except(logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x);
    return c;
  endfunction

  function automatic void feed_byte(logic [7:0] c);
    lex_row_t r;
    r    = '0;
    r.ch = c;
    feed_q = {feed_q, r};
  endfunction

  // One well-formed piece of markup with random content, or a little noise.
  function automatic void add_segment();
    logic [7:0]  markers [4] = '{CH_STAR, CH_US, CH_TILDE, CH_CARET};
    logic [7:0]  m;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) feed_byte(rnd_plain());
    end else if (pick < 50) begin
      n = $urandom_range(1, 4);
      m = markers[$urandom_range(0, 3)];
      repeat (n) feed_byte($urandom_range(0, 1) ? m : markers[$urandom_range(0, 3)]);
      feed_byte(rnd_plain());
    end else if (pick < 62) begin
      // now and then run the newline count into saturation
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
      repeat (n) feed_byte(CH_NL);
      feed_byte(rnd_plain());
    end else if (pick < 68) begin
      feed_byte(CH_BSLASH);
      feed_byte(8'($urandom_range(0, 255)));
    end else if (pick < 76) begin
      feed_byte(CH_NL);
      if ($urandom_range(0, 1)) begin
        feed_byte(CH_SLASH);
        feed_byte(CH_SLASH);
      end else begin
        feed_byte(CH_HASH);
      end
      n = $urandom_range(0, 4);
      repeat (n) feed_byte(rnd_except(CH_NL));
      feed_byte(CH_NL);
    end else if (pick < 80) begin
      feed_byte(CH_NL);
      feed_byte(CH_SLASH);
      feed_byte(rnd_plain());
    end else if (pick < 90) begin
      feed_byte(CH_LBRACE);
      n = $urandom_range(0, 3);
      repeat (n) feed_byte(rnd_except(CH_LBRACE));
      feed_byte(CH_LBRACE);
      n = $urandom_range(0, 4);
      repeat (n) feed_byte(rnd_except(CH_RBRACE));
      feed_byte(CH_RBRACE);
      n = $urandom_range(0, 4);
      repeat (n) feed_byte(rnd_except(CH_RBRACE));
      feed_byte(CH_RBRACE);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) feed_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // Both sides run without gaps over this stretch of the stream.
  function automatic bit take_gap();
    if (bytes_in >= 600 && bytes_in < 850) return 1'b0;
    return $urandom_range(0, 99) < GapPct;
  endfunction

  function automatic void chk_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", fname, want, got);
      fails++;
    end
  endfunction

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_once && bytes_in >= 300) begin
        held_once = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= rst_ni && !take_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    rtml_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (styled_q.size() == 0) begin
        $error("result with nothing expected: out_char %0h kind %0d",
               out_if.out_char, out_if.kind);
        fails++;
      end else begin
        want = styled_q.pop_front();
        chk_field("out_char", want.out_char, out_if.out_char);
        chk_field("kind", 8'(want.kind), 8'(out_if.kind));
        chk_field("new_block", 8'(want.new_block), 8'(out_if.new_block));
        chk_field("style", 8'(want.style), 8'(out_if.style));
        chk_field("separator_level", 8'(want.separator_level), 8'(out_if.separator_level));
        chk_field("last", 8'(want.last), 8'(out_if.last));
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < MaxCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $error("run timed out after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  initial begin
    int       k;
    bit       busy;
    lex_row_t cur;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_char <= 8'h00;
    cur  = '0;
    foreach (DirTab[i]) feed_q = {feed_q, DirTab[i]};
    while (feed_q.size() < DirRows + RandBytes) add_segment();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    k    = 0;
    busy = 1'b0;
    while (k < feed_q.size() || busy) begin
      @(posedge clk_i);
      if (busy && in_if.ready) begin
        lex_byte(cur.ch);
        if (cur.typed) begin
          if (!cur.none) styled_q = {styled_q, cur.res};
        end else begin
          styled_q = {styled_q, lexed};
        end
        bytes_in++;
        k++;
        busy = 1'b0;
      end
      // hold the beat while it waits; offer the next one only once it is taken
      if (!busy) begin
        if (k < feed_q.size() && !take_gap()) begin
          cur = feed_q[k];
          in_if.valid   <= 1'b1;
          in_if.in_char <= cur.ch;
          busy = 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end

    while (styled_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
